// File: design/rpct_pkg.sv
// Package for the M/S CSR and trap unit: payload structs, mode values, masks, codes.
// No dependencies.
package rpct_pkg;

  typedef enum logic [3:0] {
    FN_TICK   = 4'd0,
    FN_READ   = 4'd1,
    FN_WRITE  = 4'd2,
    FN_SET    = 4'd3,
    FN_CLEAR  = 4'd4,
    FN_EXC    = 4'd5,
    FN_ECALL  = 4'd6,
    FN_EBREAK = 4'd7,
    FN_MRET   = 4'd8,
    FN_SRET   = 4'd9
  } func_t;

  localparam logic [1:0] MODE_U = 2'd0;
  localparam logic [1:0] MODE_S = 2'd1;
  localparam logic [1:0] MODE_M = 2'd3;

  localparam logic [0:0] CFG_HART_ID  = 1'd0;
  localparam logic [0:0] CFG_ISA_WORD = 1'd1;

  localparam logic [63:0] MST_WMASK = 64'h0000_0000_007E_19AA;
  localparam logic [63:0] SST_RMASK = 64'h8000_0003_000D_E762;
  localparam logic [63:0] SST_WMASK = 64'h0000_0000_000C_0122;
  localparam logic [11:0] M_INT_MASK = 12'hAAA;
  localparam logic [11:0] S_INT_MASK = 12'h222;
  localparam logic [15:0] S_EXC_MASK = 16'hB3FF;

  typedef struct packed {
    logic [3:0]  func;
    logic [11:0] csr_address;
    logic [63:0] write_data;
    logic [5:0]  exception_cause;
    logic [63:0] trap_value;
    logic [63:0] current_pc;
    logic [3:0]  irq_lines;
    logic [63:0] retired_count;
  } in_item_t;

  typedef struct packed {
    logic [63:0] read_data;
    logic        ok;
    logic        redirect;
    logic [63:0] redirect_pc;
    logic [1:0]  priv_mode;
  } out_item_t;

  // classified operation handed from front to back
  typedef struct packed {
    logic        is_tick;
    logic        is_csr;
    logic        is_write;
    logic        is_set;
    logic        is_clear;
    logic        is_trap;
    logic        is_ecall;
    logic        is_mret;
    logic        is_sret;
    logic [5:0]  cause;
    logic [11:0] addr;
    logic [63:0] wdata;
    logic [63:0] tval;
    logic [63:0] pc;
    logic [3:0]  irq;
    logic [63:0] retired;
  } op_t;

  // highest priority interrupt: MEI, MSI, MTI, SEI, SSI, STI
  function automatic logic [3:0] int_priority(input logic [11:0] b);
    logic [3:0] r;
    r = 4'd0;
    if (b[11])     r = 4'd11;
    else if (b[3]) r = 4'd3;
    else if (b[7]) r = 4'd7;
    else if (b[9]) r = 4'd9;
    else if (b[1]) r = 4'd1;
    else if (b[5]) r = 4'd5;
    return r;
  endfunction

  function automatic logic [63:0] legal_tvec(input logic [63:0] v);
    return v[1] ? {v[63:2], 2'b00} : v;
  endfunction

endpackage

// File: design/rpct_in_if.sv
// Valid/ready request channel interface for the CSR and trap unit.
// Depends on rpct_pkg.
interface rpct_in_if;
  logic               valid;
  logic               ready;
  rpct_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: design/rpct_out_if.sv
// Result channel interface for the CSR and trap unit.
// Depends on rpct_pkg.
interface rpct_out_if;
  logic                valid;
  logic                ready;
  rpct_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: design/rpct_front.sv
// Front end: accepts requests, decodes func into an operation record,
// and queues them in a two-entry FIFO. Depends on rpct_pkg.
module rpct_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  rpct_pkg::in_item_t  in_data,
  output logic                q_valid,
  input  logic                q_pop,
  output rpct_pkg::op_t       q_op,
  output logic                q_bad
);
  rpct_pkg::op_t op_c;
  logic          bad_c;
  rpct_pkg::op_t ent_r [2];
  logic          bad_r [2];
  logic          rd_r, rd_nxt, wr_r, wr_nxt;
  logic [1:0]    cnt_r, cnt_nxt;
  logic          push;

  always_comb begin
    op_c = '0;
    bad_c = 1'b0;
    op_c.addr    = in_data.csr_address;
    op_c.wdata   = in_data.write_data;
    op_c.tval    = in_data.trap_value;
    op_c.pc      = in_data.current_pc;
    op_c.irq     = in_data.irq_lines;
    op_c.retired = in_data.retired_count;
    op_c.cause   = in_data.exception_cause;
    case (in_data.func)
      rpct_pkg::FN_TICK:   op_c.is_tick = 1'b1;
      rpct_pkg::FN_READ:   op_c.is_csr = 1'b1;
      rpct_pkg::FN_WRITE:  begin op_c.is_csr = 1'b1; op_c.is_write = 1'b1; end
      rpct_pkg::FN_SET:    begin op_c.is_csr = 1'b1; op_c.is_set = 1'b1; end
      rpct_pkg::FN_CLEAR:  begin op_c.is_csr = 1'b1; op_c.is_clear = 1'b1; end
      rpct_pkg::FN_EXC:    op_c.is_trap = 1'b1;
      rpct_pkg::FN_ECALL:  begin op_c.is_trap = 1'b1; op_c.is_ecall = 1'b1; end
      rpct_pkg::FN_EBREAK: begin
        op_c.is_trap = 1'b1;
        op_c.cause = 6'd3;
        op_c.tval = '0;
      end
      rpct_pkg::FN_MRET:   op_c.is_mret = 1'b1;
      rpct_pkg::FN_SRET:   op_c.is_sret = 1'b1;
      default:             bad_c = 1'b1;
    endcase
    if (op_c.is_ecall) op_c.tval = '0;
  end

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_op     = ent_r[rd_r];
  assign q_bad    = bad_r[rd_r];

  always_comb begin
    rd_nxt  = rd_r ^ (q_pop && q_valid);
    wr_nxt  = wr_r ^ push;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, q_pop && q_valid};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_r  <= 1'b0;
      wr_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      rd_r  <= rd_nxt;
      wr_r  <= wr_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) begin
      ent_r[wr_r] <= op_c;
      bad_r[wr_r] <= bad_c;
    end
  end
endmodule

// File: design/rpct_back.sv
// Back end: the CSR state, legality checks, trap entry and xret, with an
// output register. Depends on rpct_pkg.
module rpct_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [0:0]          cfg_idx,
  input  logic [62:0]         cfg_wdata,
  input  logic                q_valid,
  output logic                q_pop,
  input  rpct_pkg::op_t       q_op,
  input  logic                q_bad,
  output logic                out_valid,
  input  logic                out_ready,
  output rpct_pkg::out_item_t out_data
);
  logic [7:0]  hart_r;
  logic [62:0] isa_r;
  logic [63:0] mst_r, mst_nxt;
  logic [11:0] mie_r, mie_nxt, mip_r, mip_nxt, mid_r, mid_nxt;
  logic [15:0] med_r, med_nxt;
  logic [63:0] mtvec_r, mtvec_nxt, stvec_r, stvec_nxt, msc_r, msc_nxt, ssc_r, ssc_nxt;
  logic [63:0] mepc_r, mepc_nxt, sepc_r, sepc_nxt, mcause_r, mcause_nxt;
  logic [63:0] scause_r, scause_nxt, mtval_r, mtval_nxt, stval_r, stval_nxt;
  logic [2:0]  mcen_r, mcen_nxt, scen_r, scen_nxt;
  logic [63:0] satp_r, satp_nxt, cyc_r, cyc_nxt;
  logic [1:0]  mnow_r, mnow_nxt, mnext_r, mnext_nxt;
  logic        ov_r;
  rpct_pkg::out_item_t od_r, res;

  logic [1:0]  mode_c;
  logic [63:0] old, wv, tvec;
  logic        rd_ok, wr_ok, acc_ok, take, intr, to_s;
  logic [5:0]  tcause;
  logic [11:0] pend, pe, mc, sc;
  logic [63:0] sv;
  logic        fire;

  assign fire      = q_valid && (!ov_r || out_ready);
  assign q_pop     = fire;
  assign out_valid = ov_r;
  assign out_data  = od_r;

  always_comb begin
    rd_ok = 1'b1;
    old = '0;
    case (q_op.addr)
      12'hF11, 12'hF12, 12'hF13, 12'hF15, 12'h7A1: old = '0;
      12'hF14: old = {56'd0, hart_r};
      12'h300: old = mst_r;
      12'h301: old = {1'b0, isa_r};
      12'h302: old = {48'd0, med_r};
      12'h303: old = {52'd0, mid_r};
      12'h304: old = {52'd0, mie_r};
      12'h305: old = mtvec_r;
      12'h306: old = {61'd0, mcen_r};
      12'h340: old = msc_r;
      12'h341: old = mepc_r;
      12'h342: old = mcause_r;
      12'h343: old = mtval_r;
      12'h344: old = {52'd0, mip_r};
      12'hB00, 12'hC01: old = cyc_r;
      12'hB02: old = q_op.retired;
      12'h100: old = mst_r & rpct_pkg::SST_RMASK;
      12'h104: old = {52'd0, mie_r & rpct_pkg::S_INT_MASK};
      12'h105: old = stvec_r;
      12'h106: old = {61'd0, scen_r};
      12'h140: old = ssc_r;
      12'h141: old = sepc_r;
      12'h142: old = scause_r;
      12'h143: old = stval_r;
      12'h144: old = {52'd0, mip_r & rpct_pkg::S_INT_MASK};
      12'h180: begin
        old = satp_r;
        if (mnow_r == rpct_pkg::MODE_S && mst_r[20]) rd_ok = 1'b0;
      end
      12'hC00: begin
        old = cyc_r;
        if (mnow_r != rpct_pkg::MODE_M && !mcen_r[0]) rd_ok = 1'b0;
        if (mnow_r == rpct_pkg::MODE_U && !scen_r[0]) rd_ok = 1'b0;
      end
      12'h7A0: old = 64'd1;
      default: rd_ok = 1'b0;
    endcase
  end

  always_comb begin
    mst_nxt = mst_r; mie_nxt = mie_r; mip_nxt = mip_r; mid_nxt = mid_r; med_nxt = med_r;
    mtvec_nxt = mtvec_r; stvec_nxt = stvec_r; msc_nxt = msc_r; ssc_nxt = ssc_r;
    mepc_nxt = mepc_r; sepc_nxt = sepc_r; mcause_nxt = mcause_r; scause_nxt = scause_r;
    mtval_nxt = mtval_r; stval_nxt = stval_r; mcen_nxt = mcen_r; scen_nxt = scen_r;
    satp_nxt = satp_r; cyc_nxt = cyc_r; mnow_nxt = mnow_r; mnext_nxt = mnext_r;
    res = '0;
    res.ok = 1'b1;
    mode_c = mnow_r;
    pend = mip_r;
    take = 1'b0; intr = 1'b0; tcause = q_op.cause;
    wr_ok = 1'b1; acc_ok = 1'b1;
    wv = q_op.wdata; sv = '0; to_s = 1'b0; tvec = '0;
    pe = '0; mc = '0; sc = '0;
    if (q_bad) begin
      res.ok = 1'b0;
    end else if (q_op.is_tick) begin
      cyc_nxt = cyc_r + 64'd1;
      pend = {q_op.irq[0], mip_r[10], q_op.irq[3], mip_r[8], q_op.irq[2], mip_r[6:4],
              q_op.irq[1], mip_r[2:0]};
      mip_nxt = pend;
      mode_c = mnext_r;
      mnow_nxt = mnext_r;
      pe = pend & mie_r;
      mc = pe & ~mid_r;
      sc = pe & mid_r;
      if (mc != '0 && (mode_c != rpct_pkg::MODE_M || mst_r[3])) begin
        take = 1'b1; intr = 1'b1; tcause = {2'b00, rpct_pkg::int_priority(mc)};
      end else if (sc != '0 && (mode_c == rpct_pkg::MODE_U ||
                                (mode_c == rpct_pkg::MODE_S && mst_r[1]))) begin
        take = 1'b1; intr = 1'b1; tcause = {2'b00, rpct_pkg::int_priority(sc)};
      end
    end else if (q_op.is_trap) begin
      take = 1'b1;
      if (q_op.is_ecall) tcause = 6'd8 + {4'd0, mnow_r};
    end else if (q_op.is_csr) begin
      if (q_op.addr[9:8] > mnow_r ||
          ((q_op.is_write || q_op.is_set || q_op.is_clear) && q_op.addr[11:10] == 2'b11))
        acc_ok = 1'b0;
      else if (!q_op.is_write && !rd_ok)
        acc_ok = 1'b0;
      if (q_op.is_set)   wv = old | q_op.wdata;
      if (q_op.is_clear) wv = old & ~q_op.wdata;
      if (acc_ok && (q_op.is_write || q_op.is_set || q_op.is_clear)) begin
        case (q_op.addr)
          12'h300: begin
            sv = (mst_r & ~rpct_pkg::MST_WMASK) | (wv & rpct_pkg::MST_WMASK);
            if (sv[12:11] == 2'b10) sv[12:11] = 2'b00;
            mst_nxt = sv;
          end
          12'h301, 12'h7A0, 12'h7A1, 12'hC01: ;
          12'h302: med_nxt = wv[15:0] & rpct_pkg::S_EXC_MASK;
          12'h303: mid_nxt = wv[11:0] & rpct_pkg::S_INT_MASK;
          12'h304: mie_nxt = wv[11:0] & rpct_pkg::M_INT_MASK;
          12'h305: mtvec_nxt = rpct_pkg::legal_tvec(wv);
          12'h306: mcen_nxt = wv[2:0];
          12'h340: msc_nxt = wv;
          12'h341: mepc_nxt = wv;
          12'h342: mcause_nxt = wv;
          12'h343: mtval_nxt = wv;
          12'h344: mip_nxt = wv[11:0] & rpct_pkg::M_INT_MASK;
          12'hB00: cyc_nxt = wv;
          12'h100: mst_nxt = (mst_r & ~rpct_pkg::SST_WMASK) | (wv & rpct_pkg::SST_WMASK);
          12'h104: mie_nxt = (mie_r & ~rpct_pkg::S_INT_MASK) | (wv[11:0] & rpct_pkg::S_INT_MASK);
          12'h105: stvec_nxt = rpct_pkg::legal_tvec(wv);
          12'h106: scen_nxt = wv[2:0];
          12'h140: ssc_nxt = wv;
          12'h141: sepc_nxt = wv;
          12'h142: scause_nxt = wv;
          12'h143: stval_nxt = wv;
          12'h144: mip_nxt = (mip_r & ~rpct_pkg::S_INT_MASK) | (wv[11:0] & rpct_pkg::S_INT_MASK);
          12'h180: begin
            if (mnow_r == rpct_pkg::MODE_S && mst_r[20]) wr_ok = 1'b0;
            else if (wv[63:60] != 4'd0 && wv[63:60] != 4'd8) satp_nxt = {4'd0, wv[59:0]};
            else satp_nxt = wv;
          end
          default: wr_ok = 1'b0;
        endcase
      end
      res.ok = acc_ok && wr_ok;
      if (res.ok && !q_op.is_write) res.read_data = old;
    end else if (q_op.is_mret) begin
      if (mnow_r != rpct_pkg::MODE_M) begin
        res.ok = 1'b0;
      end else begin
        sv = mst_r;
        sv[3] = mst_r[7];
        sv[7] = 1'b1;
        sv[12:11] = 2'b00;
        if (mst_r[12:11] != rpct_pkg::MODE_M) sv[17] = 1'b0;
        mst_nxt = sv;
        mnext_nxt = mst_r[12:11];
        res.redirect = 1'b1;
        res.redirect_pc = mepc_r;
      end
    end else if (q_op.is_sret) begin
      if (mnow_r == rpct_pkg::MODE_U || (mnow_r == rpct_pkg::MODE_S && mst_r[22])) begin
        res.ok = 1'b0;
      end else begin
        sv = mst_r;
        sv[1] = mst_r[5];
        sv[5] = 1'b1;
        sv[8] = 1'b0;
        sv[17] = 1'b0;
        mst_nxt = sv;
        mnext_nxt = {1'b0, mst_r[8]};
        res.redirect = 1'b1;
        res.redirect_pc = sepc_r;
      end
    end

    if (take) begin
      if (mode_c != rpct_pkg::MODE_M) begin
        if (intr) to_s = (tcause < 6'd12) && mid_r[tcause[3:0]];
        else      to_s = (tcause < 6'd16) && med_r[tcause[3:0]];
      end
      sv = mst_r;
      if (to_s) begin
        stval_nxt = intr ? 64'd0 : q_op.tval;
        scause_nxt = {intr, 57'd0, tcause};
        sepc_nxt = q_op.pc;
        sv[5] = mst_r[1];
        sv[1] = 1'b0;
        sv[8] = mode_c[0];
        tvec = stvec_r;
        mnext_nxt = rpct_pkg::MODE_S;
      end else begin
        mtval_nxt = intr ? 64'd0 : q_op.tval;
        mcause_nxt = {intr, 57'd0, tcause};
        mepc_nxt = q_op.pc;
        sv[7] = mst_r[3];
        sv[3] = 1'b0;
        sv[12:11] = mode_c;
        tvec = mtvec_r;
        mnext_nxt = rpct_pkg::MODE_M;
      end
      mst_nxt = sv;
      res.redirect = 1'b1;
      res.redirect_pc = {tvec[63:2], 2'b00} +
                        ((intr && tvec[1:0] == 2'b01) ? {56'd0, tcause, 2'b00} : 64'd0);
    end
    res.priv_mode = mnext_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hart_r <= '0; isa_r <= '0; mst_r <= '0; mie_r <= '0; mip_r <= '0; mid_r <= '0;
      med_r <= '0; mtvec_r <= '0; stvec_r <= '0; msc_r <= '0; ssc_r <= '0;
      mepc_r <= '0; sepc_r <= '0; mcause_r <= '0; scause_r <= '0; mtval_r <= '0;
      stval_r <= '0; mcen_r <= '0; scen_r <= '0; satp_r <= '0; cyc_r <= '0;
      mnow_r <= rpct_pkg::MODE_M; mnext_r <= rpct_pkg::MODE_M;
      ov_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_idx == rpct_pkg::CFG_HART_ID) hart_r <= cfg_wdata[7:0];
        else isa_r <= cfg_wdata;
      end
      if (fire) begin
        mst_r <= mst_nxt; mie_r <= mie_nxt; mip_r <= mip_nxt; mid_r <= mid_nxt;
        med_r <= med_nxt; mtvec_r <= mtvec_nxt; stvec_r <= stvec_nxt; msc_r <= msc_nxt;
        ssc_r <= ssc_nxt; mepc_r <= mepc_nxt; sepc_r <= sepc_nxt; mcause_r <= mcause_nxt;
        scause_r <= scause_nxt; mtval_r <= mtval_nxt; stval_r <= stval_nxt;
        mcen_r <= mcen_nxt; scen_r <= scen_nxt; satp_r <= satp_nxt; cyc_r <= cyc_nxt;
        mnow_r <= mnow_nxt; mnext_r <= mnext_nxt;
        ov_r <= 1'b1;
      end else if (out_ready) begin
        ov_r <= 1'b0;
      end
    end
    if (fire) od_r <= res;
  end
endmodule

// File: design/riscv_privilege_csr_trap_unit.sv
// Top level of the RV64 M/S CSR file and trap unit.
// Depends on rpct_pkg, rpct_in_if, rpct_out_if, rpct_front, rpct_back.

// One request per cycle sustained while out_ready is held; a request is registered
// in the two-entry front queue, then passes through the CSR/trap logic into the
// output register. Each request is one operation on the CSR state; config
// writes (hart id, misa) take effect at once and should be done while idle.
module riscv_privilege_csr_trap_unit (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [0:0]       cfg_idx,
  input  logic [62:0]      cfg_wdata,
  rpct_in_if.sink          in_ch,
  rpct_out_if.source       out_ch
);
  logic          q_valid, q_pop, q_bad;
  rpct_pkg::op_t q_op;

  rpct_front u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_data(in_ch.data),
    .q_valid(q_valid), .q_pop(q_pop), .q_op(q_op), .q_bad(q_bad)
  );

  rpct_back u_back (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata),
    .q_valid(q_valid), .q_pop(q_pop), .q_op(q_op), .q_bad(q_bad),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data)
  );

  a_mode_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.data.priv_mode != 2'd2)) else $error("reserved mode");
  a_noredir_pc: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.data.redirect) |-> (out_ch.data.redirect_pc == 64'd0))
    else $error("stray redirect pc");
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> out_ch.valid) else $error("result lost");
endmodule
